// File: hw/rtl/mtsa_pkg.sv
// Shared types, character codes and a width helper for the mul token scanner.
`default_nettype none

package mtsa_pkg;

  localparam int MAX_DIGITS_DEF = 3;

  localparam int BYTE_W    = 8;
  localparam int PRODUCT_W = 20;
  localparam int TOTAL_W   = 63;

  localparam logic [BYTE_W-1:0] CH_M     = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h75;
  localparam logic [BYTE_W-1:0] CH_L     = 8'h6C;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_M    = 3'd1,
    PH_MU   = 3'd2,
    PH_MUL  = 3'd3,
    PH_ARG1 = 3'd4,
    PH_ARG2 = 3'd5
  } phase_t;

  typedef struct packed {
    logic done;
    logic last;
  } scan_evt_t;

  // Bits needed to hold the largest number of the given digit count.
  function automatic int num_width(input int digits);
    int maxv;
    int w;
    maxv = 1;
    w    = 1;
    for (int i = 0; i < digits; i++) begin
      maxv = maxv * 10;
    end
    maxv = maxv - 1;
    for (int i = 0; i < 31; i++) begin
      if ((maxv >> i) != 0) begin
        w = i + 1;
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mul_token_scan_accumulate.sv
// Top level: mul(A,B) scanner with saturating product accumulator and result register.
//
// The block reads one text byte per item and finds each mul(A,B) with one to
// MAX_DIGITS decimal digits per number. A byte that closes a match yields a
// result with the product and the updated total; the byte flagged as end of
// text yields a result with the total and then clears the total and scanner.
// Other bytes yield no result. Items are taken one per cycle: a byte passes a
// scanner stage, where the product is formed by one multiplier, and then the
// accumulator stage, where a 63-bit add with saturation feeds the result
// register. An accepted byte is registered in the scanner stage, and its result
// is loaded into the result register when the scanner stage pops it. A result
// that waits for out_ready holds the scanner stage, which then holds the input.
`default_nettype none

module mul_token_scan_accumulate #(
  parameter int MAX_DIGITS = mtsa_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mtsa_pkg::BYTE_W-1:0]    in_byte_in,
  input  wire logic                           in_end_of_text,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mtsa_pkg::PRODUCT_W-1:0]      out_product,
  output logic                                out_product_valid,
  output logic [mtsa_pkg::TOTAL_W-1:0]        out_running_total,
  output logic                                out_is_final
);
  import mtsa_pkg::*;

  localparam int NUM_W  = num_width(MAX_DIGITS);
  localparam int PROD_W = 2 * NUM_W;

  logic                 evt_valid;
  scan_evt_t            evt;
  logic [PROD_W-1:0]    prod;
  logic                 res_free;
  logic                 pop;
  logic                 has_result;
  logic [TOTAL_W:0]     sum_wide;
  logic [TOTAL_W-1:0]   sum_sat;

  logic [TOTAL_W-1:0]   sum_r, sum_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PRODUCT_W-1:0] out_product_r;
  logic                 out_product_valid_r;
  logic [TOTAL_W-1:0]   out_running_total_r;
  logic                 out_is_final_r;

  mtsa_scan #(
    .MAX_DIGITS (MAX_DIGITS),
    .NUM_W      (NUM_W),
    .PROD_W     (PROD_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_in     (in_byte_in),
    .end_of_text (in_end_of_text),
    .pop         (pop),
    .evt_valid   (evt_valid),
    .evt         (evt),
    .prod        (prod)
  );

  assign res_free   = !out_valid_r || out_ready;
  assign pop        = evt_valid && res_free;
  assign has_result = evt.done || evt.last;

  assign sum_wide = {1'b0, sum_r} + (TOTAL_W + 1)'(evt.done ? prod : '0);
  assign sum_sat  = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];

  always_comb begin
    sum_nxt = sum_r;
    if (pop) begin
      sum_nxt = evt.last ? '0 : sum_sat;
    end
    out_valid_nxt = (out_valid_r && !out_ready) || (pop && has_result);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      out_product_r       <= evt.done ? PRODUCT_W'(prod) : '0;
      out_product_valid_r <= evt.done;
      out_running_total_r <= sum_sat;
      out_is_final_r      <= evt.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product       = out_product_r;
  assign out_product_valid = out_product_valid_r;
  assign out_running_total = out_running_total_r;
  assign out_is_final      = out_is_final_r;

  // A result always carries either a product or the end-of-text total.
  a_result_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_product_valid || out_is_final))
    else $error("result without product or final flag");

  // A result without a product shows a zero product.
  a_no_product_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_product_valid) |-> (out_product == '0))
    else $error("nonzero product on a result without a match");

  // The total is cleared once the final byte leaves the scanner stage.
  a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && evt.last) |=> (sum_r == '0))
    else $error("total not cleared after the final item");

  // The reported total never falls below the product it includes.
  a_total_covers_product: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_product_valid) |-> (out_running_total >= TOTAL_W'(out_product)))
    else $error("total smaller than reported product");

endmodule

`default_nettype wire

// File: hw/rtl/mtsa_scan.sv
// Pattern scanner: tracks the mul(A,B) phases, builds both numbers and forms A*B.
`default_nettype none

module mtsa_scan #(
  parameter int MAX_DIGITS = mtsa_pkg::MAX_DIGITS_DEF,
  parameter int NUM_W      = mtsa_pkg::num_width(MAX_DIGITS),
  parameter int PROD_W     = 2 * NUM_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mtsa_pkg::BYTE_W-1:0] byte_in,
  input  wire logic                        end_of_text,
  input  wire logic                        pop,
  output logic                             evt_valid,
  output mtsa_pkg::scan_evt_t              evt,
  output logic [PROD_W-1:0]                prod
);
  import mtsa_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NUM_W-1:0]   first_r, first_nxt;
  logic [NUM_W-1:0]   second_r, second_nxt;
  logic               evt_valid_r, evt_valid_nxt;
  scan_evt_t          evt_r, evt_nxt;
  logic [PROD_W-1:0]  prod_r;

  logic               accept;
  logic               is_digit;
  logic               in_arg;
  logic               m_start;
  logic               u_ok;
  logic               l_ok;
  logic               open_ok;
  logic               dig_take;
  logic               comma_ok;
  logic               close_ok;
  logic               keep;
  logic [NUM_W-1:0]   digit_val;
  logic [NUM_W-1:0]   cur_num;
  logic [NUM_W-1:0]   new_num;

  assign in_ready = !evt_valid_r || pop;
  assign accept   = in_valid && in_ready;

  assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign in_arg    = (phase_r == PH_ARG1) || (phase_r == PH_ARG2);
  assign m_start   = (byte_in == CH_M) && (phase_r == PH_IDLE);
  assign u_ok      = (byte_in == CH_U) && (phase_r == PH_M);
  assign l_ok      = (byte_in == CH_L) && (phase_r == PH_MU);
  assign open_ok   = (byte_in == CH_OPEN) && (phase_r == PH_MUL);
  assign dig_take  = is_digit && in_arg && (cnt_r < CNT_W'(MAX_DIGITS));
  assign comma_ok  = (byte_in == CH_COMMA) && (phase_r == PH_ARG1) && (cnt_r != '0);
  assign close_ok  = (byte_in == CH_CLOSE) && (phase_r == PH_ARG2) && (cnt_r != '0);
  assign keep      = u_ok || l_ok || open_ok || dig_take || comma_ok;

  assign digit_val = NUM_W'(byte_in[3:0]);
  assign cur_num   = (phase_r == PH_ARG1) ? first_r : second_r;
  assign new_num   = NUM_W'({cur_num, 3'b000}) + NUM_W'({cur_num, 1'b0}) + digit_val;

  always_comb begin
    phase_nxt = PH_IDLE;
    if (!end_of_text) begin
      priority if (m_start) begin
        phase_nxt = PH_M;
      end else if (u_ok) begin
        phase_nxt = PH_MU;
      end else if (l_ok) begin
        phase_nxt = PH_MUL;
      end else if (open_ok) begin
        phase_nxt = PH_ARG1;
      end else if (dig_take) begin
        phase_nxt = phase_r;
      end else if (comma_ok) begin
        phase_nxt = PH_ARG2;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    if (open_ok) begin
      cnt_nxt   = '0;
      first_nxt = '0;
    end
    if (dig_take) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (phase_r == PH_ARG1) begin
        first_nxt = new_num;
      end else begin
        second_nxt = new_num;
      end
    end
    if (comma_ok) begin
      cnt_nxt    = '0;
      second_nxt = '0;
    end
    if (!keep || end_of_text) begin
      cnt_nxt    = '0;
      first_nxt  = '0;
      second_nxt = '0;
    end
    evt_nxt.done  = close_ok;
    evt_nxt.last  = end_of_text;
    evt_valid_nxt = accept || (evt_valid_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      evt_valid_r <= 1'b0;
      evt_r       <= '0;
    end else begin
      evt_valid_r <= evt_valid_nxt;
      if (accept) begin
        phase_r  <= phase_nxt;
        cnt_r    <= cnt_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        evt_r    <= evt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= PROD_W'(first_r) * PROD_W'(second_r);
    end
  end

  assign evt_valid = evt_valid_r;
  assign evt       = evt_r;
  assign prod      = prod_r;

endmodule

`default_nettype wire
